// ----- rtl/scsa_pkg.sv -----
`timescale 1ns / 1ps
package scsa_pkg;

  localparam int unsigned OFFSET_BITS_DEF       = 16;
  localparam int unsigned PAGE_BYTES_DEF        = 4096;
  localparam int unsigned NUM_CLASSES_DEF       = 10;
  localparam int unsigned PAGE_HEADER_BYTES_DEF = 16;
  localparam int unsigned SLAB_HEADER_BYTES_DEF = 256;

  localparam int unsigned MIN_CLASS_BYTES  = 16;
  localparam int unsigned MIN_CLASS_SHIFT  = 4;
  localparam int unsigned MAX_CLASS_BYTES  = 8192;
  localparam int unsigned BITMAP_ITEM_CAP  = 8192;
  localparam int unsigned CLS_IDX_W        = 4;
  localparam int unsigned LINK_ADDR_W      = 13;
  localparam int unsigned OFF_W            = 16;
  localparam int unsigned CFG_DATA_W       = 17;
  localparam int unsigned REGION_START_RST = 0;
  localparam int unsigned REGION_SIZE_RST  = 65536;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_CARVE
  } state_e;

  typedef struct packed {
    logic                   valid;
    logic [CLS_IDX_W-1:0]   idx;
  } cls_t;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [LINK_ADDR_W-1:0] addr;
    logic [OFF_W-1:0]       wdata;
  } mem_req_t;

  // bytes in front of the first chunk of a page of class k
  function automatic int unsigned carve_payload(int unsigned k, int unsigned page,
                                                int unsigned ph);
    int unsigned items;
    items = (page - ph) >> (k + MIN_CLASS_SHIFT);
    if (items > BITMAP_ITEM_CAP) items = BITMAP_ITEM_CAP;
    return ph + ((items + 7) >> 3);
  endfunction

  // chunks per page of class k
  function automatic int unsigned carve_cap(int unsigned k, int unsigned page,
                                            int unsigned ph);
    int unsigned payload;
    payload = carve_payload(k, page, ph);
    return (payload < page) ? ((page - payload) >> (k + MIN_CLASS_SHIFT)) : 0;
  endfunction

endpackage

// ----- rtl/size_class_slab_allocator_core.sv -----
`timescale 1ns / 1ps
// Flow: a free or failed request is answered from EXEC; an alloc from a free list
// reads link memory in EXEC and answers from POP; an alloc that carves a page walks
// CARVE, one link write per cycle, the last held until the result slot is free.
// Throughput: one request at a time; the next beat is taken the cycle after work ends.
// Reset: all free lists empty, bump pointer at region start plus slab header.
// Link memory is not cleared; entries are only read after being written.
module size_class_slab_allocator_core #(
  parameter int unsigned OFFSET_BITS       = scsa_pkg::OFFSET_BITS_DEF,
  parameter int unsigned PAGE_BYTES        = scsa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned NUM_CLASSES       = scsa_pkg::NUM_CLASSES_DEF,
  parameter int unsigned PAGE_HEADER_BYTES = scsa_pkg::PAGE_HEADER_BYTES_DEF,
  parameter int unsigned SLAB_HEADER_BYTES = scsa_pkg::SLAB_HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] size_bytes_i,
  input  logic [15:0] chunk_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] alloc_offset_o,
  output logic        ok_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned SlotW = ((OFFSET_BITS > 16) ? 16 : OFFSET_BITS) - 3;

  scsa_pkg::cls_t     cls;
  scsa_pkg::mem_req_t mem_req;
  logic [15:0]        mem_rdata;

  scsa_class #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_class (
    .size_bytes_i (size_bytes_i),
    .cls_o        (cls)
  );

  scsa_ctrl #(
    .OFFSET_BITS       (OFFSET_BITS),
    .PAGE_BYTES        (PAGE_BYTES),
    .NUM_CLASSES       (NUM_CLASSES),
    .PAGE_HEADER_BYTES (PAGE_HEADER_BYTES),
    .SLAB_HEADER_BYTES (SLAB_HEADER_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .chunk_offset_i (chunk_offset_i),
    .cls_i          (cls),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .alloc_offset_o (alloc_offset_o),
    .ok_o           (ok_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

  scsa_link_mem #(
    .SLOT_W (SlotW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- rtl/scsa_class.sv -----
`timescale 1ns / 1ps
module scsa_class #(
  parameter int unsigned NUM_CLASSES = scsa_pkg::NUM_CLASSES_DEF
) (
  input  logic [15:0]     size_bytes_i,
  output scsa_pkg::cls_t  cls_o
);

  logic [16:0] size_r8;

  always_comb begin
    size_r8 = ({1'b0, size_bytes_i} + 17'd7) & ~17'd7;
    cls_o   = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (size_r8 <= 17'(scsa_pkg::MIN_CLASS_BYTES << k) &&
          size_r8 <= 17'(scsa_pkg::MAX_CLASS_BYTES)) begin
        cls_o.valid = 1'b1;
        cls_o.idx   = scsa_pkg::CLS_IDX_W'(k);
      end
    end
  end

endmodule

// ----- rtl/scsa_link_mem.sv -----
`timescale 1ns / 1ps
module scsa_link_mem #(
  parameter int unsigned SLOT_W = 13
) (
  input  logic               clk_i,
  input  scsa_pkg::mem_req_t req_i,
  output logic [15:0]        rdata_o
);

  logic [15:0] mem_q [2**SLOT_W];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr[SLOT_W-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr[SLOT_W-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/scsa_ctrl.sv -----
`timescale 1ns / 1ps
module scsa_ctrl #(
  parameter int unsigned OFFSET_BITS       = scsa_pkg::OFFSET_BITS_DEF,
  parameter int unsigned PAGE_BYTES        = scsa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned NUM_CLASSES       = scsa_pkg::NUM_CLASSES_DEF,
  parameter int unsigned PAGE_HEADER_BYTES = scsa_pkg::PAGE_HEADER_BYTES_DEF,
  parameter int unsigned SLAB_HEADER_BYTES = scsa_pkg::SLAB_HEADER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [15:0]        chunk_offset_i,
  input  scsa_pkg::cls_t     cls_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        alloc_offset_o,
  output logic               ok_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  output scsa_pkg::mem_req_t mem_req_o,
  input  logic [15:0]        mem_rdata_i
);

  localparam int unsigned SlotW    = ((OFFSET_BITS > 16) ? 16 : OFFSET_BITS) - 3;
  localparam int unsigned ClsW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned CntW     = $clog2(PAGE_BYTES / 16 + 1);
  localparam int unsigned LimBytes = (OFFSET_BITS >= 16) ? 65536 : (1 << OFFSET_BITS);

  scsa_pkg::state_e state_q, state_d;

  logic        func_q, func_d;
  logic [15:0] off_q, off_d;
  logic [ClsW-1:0] cls_q, cls_d;
  logic        cls_ok_q, cls_ok_d;
  logic [15:0] head_q, head_d;
  logic [15:0] heads_q [NUM_CLASSES];
  logic [15:0] heads_d [NUM_CLASSES];
  logic [16:0] bump_q, bump_d;
  logic [16:0] end_q, end_d;
  logic [15:0] start_q, start_d;
  logic [16:0] size_q, size_d;
  logic [15:0] carve_off_q, carve_off_d;
  logic [15:0] prev_q, prev_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_off_q, out_off_d;
  logic        out_ok_q, out_ok_d;

  logic [CntW-1:0] cap;
  logic [16:0] payload;
  logic [13:0] item;
  logic [17:0] bump_next;
  logic [17:0] region_sum;
  logic        res_free;
  logic [15:0] cls_head;

  always_comb begin
    cap     = '0;
    payload = '0;
    for (int j = 0; j < NUM_CLASSES; j++) begin
      if (cls_q == ClsW'(j)) begin
        cap     = CntW'(scsa_pkg::carve_cap(j, PAGE_BYTES, PAGE_HEADER_BYTES));
        payload = 17'(scsa_pkg::carve_payload(j, PAGE_BYTES, PAGE_HEADER_BYTES));
      end
    end
  end

  assign item      = 14'(scsa_pkg::MIN_CLASS_BYTES) << cls_q;
  assign bump_next = {1'b0, bump_q} + 18'(PAGE_BYTES);
  assign res_free  = !out_valid_q || out_ready_i;
  assign cls_head  = heads_q[cls_q];

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    off_d       = off_q;
    cls_d       = cls_q;
    cls_ok_d    = cls_ok_q;
    head_d      = head_q;
    heads_d     = heads_q;
    bump_d      = bump_q;
    end_d       = end_q;
    start_d     = start_q;
    size_d      = size_q;
    carve_off_d = carve_off_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_off_d   = out_off_q;
    out_ok_d    = out_ok_q;
    mem_req_o   = '0;
    region_sum  = '0;

    case (state_q)
      scsa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          func_d   = func_i;
          off_d    = chunk_offset_i;
          cls_d    = cls_i.idx[ClsW-1:0];
          cls_ok_d = cls_i.valid;
          state_d  = scsa_pkg::ST_EXEC;
        end
      end
      scsa_pkg::ST_EXEC: begin
        if (res_free) begin
          state_d   = scsa_pkg::ST_IDLE;
          out_off_d = '0;
          out_ok_d  = 1'b0;
          if (func_q == scsa_pkg::FUNC_FREE) begin
            out_valid_d = 1'b1;
            if (off_q != '0 && cls_ok_q) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = scsa_pkg::LINK_ADDR_W'(off_q[3 +: SlotW]);
              mem_req_o.wdata = cls_head;
              heads_d[cls_q]  = off_q;
              out_ok_d        = 1'b1;
            end
          end else if (!cls_ok_q) begin
            out_valid_d = 1'b1;
          end else if (cls_head != '0) begin
            mem_req_o.re   = 1'b1;
            mem_req_o.addr = scsa_pkg::LINK_ADDR_W'(cls_head[3 +: SlotW]);
            head_d         = cls_head;
            state_d        = scsa_pkg::ST_POP;
          end else if (bump_next > {1'b0, end_q}) begin
            out_valid_d = 1'b1;
          end else begin
            bump_d = bump_next[16:0];
            if (cap == '0) begin
              out_valid_d = 1'b1;
            end else begin
              carve_off_d = 16'(bump_q + payload);
              prev_d      = '0;
              cnt_d       = '0;
              state_d     = scsa_pkg::ST_CARVE;
            end
          end
        end
      end
      scsa_pkg::ST_POP: begin
        if (res_free) begin
          heads_d[cls_q] = mem_rdata_i;
          out_valid_d    = 1'b1;
          out_off_d      = head_q;
          out_ok_d       = 1'b1;
          state_d        = scsa_pkg::ST_IDLE;
        end
      end
      scsa_pkg::ST_CARVE: begin
        if (cnt_q != cap - CntW'(1) || res_free) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = scsa_pkg::LINK_ADDR_W'(carve_off_q[3 +: SlotW]);
          mem_req_o.wdata = prev_q;
          if (cnt_q == cap - CntW'(1)) begin
            // last chunk goes straight out; its link becomes the head
            heads_d[cls_q] = prev_q;
            out_valid_d    = 1'b1;
            out_off_d      = carve_off_q;
            out_ok_d       = 1'b1;
            state_d        = scsa_pkg::ST_IDLE;
          end else begin
            prev_d      = carve_off_q;
            carve_off_d = carve_off_q + 16'(item);
            cnt_d       = cnt_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = scsa_pkg::ST_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      if (cfg_index_i == scsa_pkg::CFG_REGION_START) begin
        start_d = cfg_data_i[15:0];
      end else begin
        size_d = cfg_data_i;
      end
      for (int j = 0; j < NUM_CLASSES; j++) begin
        heads_d[j] = '0;
      end
      bump_d     = {1'b0, start_d} + 17'(SLAB_HEADER_BYTES);
      region_sum = {2'b0, start_d} + {1'b0, size_d};
      end_d      = (region_sum > 18'(LimBytes)) ? 17'(LimBytes) : region_sum[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scsa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NUM_CLASSES; j++) begin
        heads_q[j] <= '0;
      end
      start_q <= 16'(scsa_pkg::REGION_START_RST);
      size_q  <= 17'(scsa_pkg::REGION_SIZE_RST);
      bump_q  <= 17'(scsa_pkg::REGION_START_RST + SLAB_HEADER_BYTES);
      end_q   <= 17'(LimBytes);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      heads_q     <= heads_d;
      start_q     <= start_d;
      size_q      <= size_d;
      bump_q      <= bump_d;
      end_q       <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    off_q       <= off_d;
    cls_q       <= cls_d;
    cls_ok_q    <= cls_ok_d;
    head_q      <= head_d;
    carve_off_q <= carve_off_d;
    prev_q      <= prev_d;
    cnt_q       <= cnt_d;
    out_off_q   <= out_off_d;
    out_ok_q    <= out_ok_d;
  end

  assign in_ready_o     = (state_q == scsa_pkg::ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign alloc_offset_o = out_off_q;
  assign ok_o           = out_ok_q;

endmodule

// ----- rtl/scsa_chk.sv -----
`timescale 1ns / 1ps
module scsa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] alloc_offset_o,
  input logic        ok_o
);

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(alloc_offset_o) && $stable(ok_o))
    else $error("result beat changed while stalled");

  // failed requests never carry an offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> alloc_offset_o == '0)
    else $error("failed result with nonzero offset");

  // a request keeps the block busy: input is not ready in the cycle after a beat is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

  // a result never appears in the cycle right after an input beat
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind size_class_slab_allocator_core scsa_chk u_chk (.*);

// ----- tb/sv/scsa_alloc_checker.sv -----
`timescale 1ns / 1ps
module scsa_alloc_checker
  import scsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              func_i,
  input  logic [15:0]       size_bytes_i,
  input  logic [15:0]       chunk_offset_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [15:0]       alloc_offset_i,
  input  logic              ok_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [16:0]       cfg_data_i,
  output int unsigned       pending_o,
  output int unsigned       errors_o
);

  localparam int unsigned LINK_DEPTH = 1 << LINK_ADDR_W;

  typedef struct packed {
    logic [15:0] offset;
    logic        ok;
  } grant_t;

  logic [15:0] link_mem [LINK_DEPTH];
  int unsigned heads [NUM_CLASSES_DEF];
  int unsigned bump;
  int unsigned reg_start;
  int unsigned reg_size;
  int unsigned errors;
  grant_t      grants_q [$];

  function automatic int unsigned link_slot(int unsigned off);
    return (off >> 3) % LINK_DEPTH;
  endfunction

  function automatic int class_index(logic [15:0] sz);
    int unsigned rounded;
    int          k;
    rounded = (32'(sz) + 7) & ~32'd7;
    if (rounded > MAX_CLASS_BYTES) return -1;
    for (k = 0; k < NUM_CLASSES_DEF; k++) begin
      if (rounded <= (MIN_CLASS_BYTES << k)) return k;
    end
    return -1;
  endfunction

  function automatic int unsigned region_limit();
    int unsigned e;
    int unsigned lim;
    e   = reg_start + reg_size;
    lim = (OFFSET_BITS_DEF >= 16) ? 32'd65536 : (32'd1 << OFFSET_BITS_DEF);
    return (e > lim) ? lim : e;
  endfunction

  function automatic void restart_region();
    int k;
    for (k = 0; k < NUM_CLASSES_DEF; k++) heads[k] = 0;
    bump = reg_start + SLAB_HEADER_BYTES_DEF;
  endfunction

  // new page for class k, chunks linked so the highest address pops first
  function automatic bit carve_page(int k);
    int unsigned chunk, base, items, lead, cap, prev, off, i;
    chunk = MIN_CLASS_BYTES << k;
    base  = bump;
    if (base + PAGE_BYTES_DEF > region_limit()) return 1'b0;
    bump  = base + PAGE_BYTES_DEF;
    items = (PAGE_BYTES_DEF - PAGE_HEADER_BYTES_DEF) / chunk;
    if (items > BITMAP_ITEM_CAP) items = BITMAP_ITEM_CAP;
    lead  = PAGE_HEADER_BYTES_DEF + (items + 7) / 8;
    cap   = (lead < PAGE_BYTES_DEF) ? (PAGE_BYTES_DEF - lead) / chunk : 0;
    if (cap == 0) return 1'b0;
    prev = heads[k];
    for (i = 0; i < cap; i++) begin
      off = base + lead + i * chunk;
      link_mem[link_slot(off)] = 16'(prev);
      prev = off;
    end
    heads[k] = prev;
    return 1'b1;
  endfunction

  function automatic grant_t serve_request(logic f, logic [15:0] sz, logic [15:0] off);
    grant_t      g;
    int          k;
    int unsigned head;
    g = '0;
    k = class_index(sz);
    if (f == FUNC_ALLOC) begin
      if (k < 0) return g;
      if (heads[k] == 0 && !carve_page(k)) return g;
      head     = heads[k];
      heads[k] = link_mem[link_slot(head)];
      g.offset = 16'(head);
      g.ok     = 1'b1;
    end else begin
      if (off == 16'd0 || k < 0) return g;
      link_mem[link_slot(off)] = 16'(heads[k]);
      heads[k] = off;
      g.ok     = 1'b1;
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t want;
    if (!rst_ni) begin
      reg_start = REGION_START_RST;
      reg_size  = REGION_SIZE_RST;
      restart_region();
      grants_q.delete();
      errors    = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_REGION_START) begin
          reg_start = cfg_data_i[15:0];
        end else begin
          reg_size = cfg_data_i;
        end
        restart_region();
      end
      if (in_valid_i && in_ready_i) begin
        grants_q.push_back(serve_request(func_i, size_bytes_i, chunk_offset_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (grants_q.size() == 0) begin
          $error("unexpected result beat: alloc_offset 0x%04h ok %b", alloc_offset_i, ok_i);
          errors++;
        end else begin
          want = grants_q.pop_front();
          if (alloc_offset_i !== want.offset) begin
            $error("alloc_offset: expected 0x%04h, got 0x%04h", want.offset, alloc_offset_i);
            errors++;
          end
          if (ok_i !== want.ok) begin
            $error("ok: expected %b, got %b", want.ok, ok_i);
            errors++;
          end
        end
      end
      pending_o <= grants_q.size();
      errors_o  <= errors;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import scsa_pkg::*;

  localparam int unsigned N_ITEMS = 1300;
  localparam int unsigned N_QUIET = 100;

  typedef struct packed {
    logic        f;
    logic [15:0] sz;
  } req_t;

  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] sz;
  } chunk_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        func         = FUNC_ALLOC;
  logic [15:0] size_bytes   = '0;
  logic [15:0] chunk_offset = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [15:0] alloc_offset;
  logic        ok;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic        cfg_index    = CFG_REGION_START;
  logic [16:0] cfg_data     = '0;

  int unsigned n_pending;
  int unsigned n_errors;
  int unsigned n_sent = 0;
  bit          calm   = 1'b0;
  bit          quiet  = 1'b0;

  req_t        sent_q [$];
  chunk_t      live_q [$];

  int unsigned rx_gap, rx_hold, rx_beats;

  always #5 clk = ~clk;

  size_class_slab_allocator_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .size_bytes_i   (size_bytes),
    .chunk_offset_i (chunk_offset),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .alloc_offset_o (alloc_offset),
    .ok_o           (ok),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  scsa_alloc_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (func),
    .size_bytes_i   (size_bytes),
    .chunk_offset_i (chunk_offset),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .alloc_offset_i (alloc_offset),
    .ok_i           (ok),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (n_pending),
    .errors_o       (n_errors)
  );

  // result side: random stalls plus two long hold-offs
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
      rx_hold   <= 0;
      rx_beats  <= 0;
    end else begin
      if (out_valid && out_ready) rx_beats <= rx_beats + 1;
      if (rx_hold != 0) begin
        rx_hold   <= rx_hold - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && !quiet && (rx_beats == 50 || rx_beats == 600)) begin
        rx_hold   <= 300;
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap    <= rx_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
        rx_gap    <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // live chunks for well-formed frees; sampled mid-cycle
  always @(negedge clk) begin : track_live
    req_t r;
    if (in_valid && in_ready) sent_q.push_back('{func, size_bytes});
    if (out_valid && out_ready && sent_q.size() != 0) begin
      r = sent_q.pop_front();
      if (r.f == FUNC_ALLOC && ok === 1'b1 && alloc_offset != 16'd0) begin
        live_q.push_back('{alloc_offset, r.sz});
      end
    end
  end

  task automatic send_item(input logic f, input logic [15:0] sz, input logic [15:0] off);
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    size_bytes   <= sz;
    chunk_offset <= off;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_region(input logic [15:0] start, input logic [16:0] span);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_REGION_START;
    cfg_data  <= {1'b0, start};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_REGION_SIZE;
    cfg_data  <= span;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_size();
    int          r, k;
    int unsigned lo, hi;
    r = $urandom_range(0, 99);
    if (r < 55) k = $urandom_range(0, 2);
    else if (r < 90) k = $urandom_range(3, 6);
    else if (r < 97) k = 7;
    else k = $urandom_range(8, 9);
    hi = MIN_CLASS_BYTES << k;
    lo = (k == 0) ? 0 : (hi >> 1) + 1;
    if ($urandom_range(0, 7) == 0) return 16'(hi);
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic random_item();
    int     r;
    int     idx;
    chunk_t c;
    r = $urandom_range(0, 99);
    if (live_q.size() != 0 && (r < 35 || live_q.size() > 300)) begin
      idx = $urandom_range(0, live_q.size() - 1);
      c   = live_q[idx];
      live_q.delete(idx);
      send_item(FUNC_FREE, c.sz, c.offset);
    end else if (r < 90) begin
      send_item(FUNC_ALLOC, pick_size(), 16'($urandom));
    end else begin
      send_item($urandom_range(0, 1) ? FUNC_FREE : FUNC_ALLOC, 16'($urandom),
                (r < 93) ? 16'd0 : 16'($urandom));
    end
  endtask

  task automatic random_region();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: set_region(16'($urandom_range(0, 8192)), 17'h10000);
      4, 5:       set_region(16'($urandom_range(0, 16383)), 17'($urandom_range(4352, 40000)));
      6:          set_region(16'hFFFF, 17'h10000);
      7:          set_region(16'h0000, 17'h00000);
      default:    set_region(16'($urandom), 17'($urandom_range(0, 65536)));
    endcase
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset region: classes, boundaries, unchecked frees
    send_item(FUNC_ALLOC, 16'd0, 16'd0);
    send_item(FUNC_ALLOC, 16'd1, 16'hFFFF);
    send_item(FUNC_ALLOC, 16'd16, 16'd0);
    send_item(FUNC_ALLOC, 16'd17, 16'd0);
    send_item(FUNC_ALLOC, 16'd8185, 16'd0);
    send_item(FUNC_ALLOC, 16'd4096, 16'd0);
    send_item(FUNC_ALLOC, 16'd2048, 16'd0);
    send_item(FUNC_ALLOC, 16'd8193, 16'd0);
    send_item(FUNC_ALLOC, 16'hFFFF, 16'd0);
    send_item(FUNC_FREE, 16'd16, 16'd0);
    send_item(FUNC_FREE, 16'd9000, 16'h1234);
    send_item(FUNC_FREE, 16'd64, 16'hFFFF);
    send_item(FUNC_ALLOC, 16'd64, 16'd0);
    send_item(FUNC_FREE, 16'd8192, 16'hFFF8);
    send_item(FUNC_ALLOC, 16'd8192, 16'd0);
    send_item(FUNC_FREE, 16'd0, 16'h8000);
    send_item(FUNC_ALLOC, 16'd0, 16'd0);

    // exactly one page fits
    drain();
    set_region(16'h0000, 17'd4352);
    send_item(FUNC_ALLOC, 16'd2048, 16'd0);
    send_item(FUNC_ALLOC, 16'd2048, 16'd0);

    drain();
    set_region(16'hFFFF, 17'h10000);
    send_item(FUNC_ALLOC, 16'd16, 16'd0);

    drain();
    set_region(16'h0000, 17'h00000);
    send_item(FUNC_ALLOC, 16'd16, 16'd0);
    send_item(FUNC_FREE, 16'd16, 16'h0100);
    send_item(FUNC_ALLOC, 16'd16, 16'd0);

    while (n_sent < N_ITEMS) begin
      drain();
      random_region();
      calm  <= ($urandom_range(0, 3) == 0);
      quiet <= (n_sent >= N_ITEMS - N_QUIET);
      repeat ($urandom_range(40, 120)) random_item();
    end

    drain();
    repeat (6) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("size_class_slab_allocator_core: match");
    end else begin
      $display("size_class_slab_allocator_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #15ms;
    $display("size_class_slab_allocator_core: mismatch");
    $finish;
  end

endmodule
